/* src/opfd_pkg.sv */
// Shared types, constants and the checksum function for the OOK pulse frame decoder.
// No dependencies; used by every module of the block.
package opfd_pkg;

    localparam int MIN_SEQUENCE = 87;
    localparam int FRAME_BITS   = 40;
    localparam int DATA_ITEMS   = 2 * FRAME_BITS;
    localparam int DATA_NEEDED  = 2 * FRAME_BITS - 1;

    localparam int ICNT_W = $clog2(MIN_SEQUENCE + 1);
    localparam int DCNT_W = $clog2(DATA_ITEMS + 1);
    localparam int BITS_W = $clog2(FRAME_BITS + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] ZERO_MASK  = 32'h00ff_0fff;
    localparam logic [7:0]  CHECK_POLY = 8'h31;

    localparam int PRE_LEN = 8;

    // preamble windows, exclusive bounds
    localparam logic signed [15:0] PRE_A_LO = 16'sd300;
    localparam logic signed [15:0] PRE_A_HI = 16'sd450;
    localparam logic signed [15:0] PRE_B_LO = 16'sd700;
    localparam logic signed [15:0] PRE_B_HI = 16'sd850;
    localparam logic signed [15:0] PRE_C_LO = 16'sd850;
    localparam logic signed [15:0] PRE_C_HI = 16'sd1000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MARK_MIN = 3'd0,
        REG_MARK_MAX = 3'd1,
        REG_PAIR_MIN = 3'd2,
        REG_PAIR_MAX = 3'd3,
        REG_ONE_THR  = 3'd4,
        REG_SEED     = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_SHORT  = 3'd1,
        ST_NO_PRE = 3'd2,
        ST_BAD    = 3'd3,
        ST_ZERO   = 3'd4,
        ST_CHK    = 3'd5
    } t_status;

    typedef struct packed {
        logic [14:0] mark_min;
        logic [14:0] mark_max;
        logic [15:0] pair_min;
        logic [15:0] pair_max;
        logic [14:0] one_thr;
        logic [7:0]  seed;
    } t_cfg;

    // classified duration as it travels through the queue
    typedef struct packed {
        logic [15:0] duration;
        logic        last;
        logic        pre_a;
        logic        pre_b;
        logic        pre_c;
        logic        mark_ok;
        logic        is_one;
    } t_item;

    typedef struct packed {
        logic pre_a;
        logic pre_b;
        logic pre_c;
    } t_pre;

    function automatic logic [7:0] check_of(input logic [7:0] seed, input logic [31:0] data);
        logic [7:0] s;
        s = seed ^ data[7:0] ^ data[15:8] ^ data[23:16] ^ data[31:24];
        for (int i = 0; i < 8; i++) begin
            if (s[7]) begin
                s = {s[6:0], 1'b0} ^ CHECK_POLY;
            end else begin
                s = {s[6:0], 1'b0};
            end
        end
        return s;
    endfunction

endpackage

/* src/opfd_front.sv */
// Front end: classifies one incoming duration against the preamble and data windows.
// Depends on opfd_pkg.
module opfd_front (
    input  logic [15:0]      i_duration,
    input  logic             i_last_item,
    input  opfd_pkg::t_cfg   i_cfg,
    output opfd_pkg::t_item  o_item
);

    logic signed [15:0] w_dur;

    assign w_dur = $signed(i_duration);

    always_comb begin
        o_item.duration = i_duration;
        o_item.last     = i_last_item;
        o_item.pre_a    = (w_dur > opfd_pkg::PRE_A_LO) && (w_dur < opfd_pkg::PRE_A_HI);
        o_item.pre_b    = (w_dur > opfd_pkg::PRE_B_LO) && (w_dur < opfd_pkg::PRE_B_HI);
        o_item.pre_c    = (w_dur > opfd_pkg::PRE_C_LO) && (w_dur < opfd_pkg::PRE_C_HI);
        o_item.mark_ok  = (w_dur >= $signed({1'b0, i_cfg.mark_min}))
                       && (w_dur <= $signed({1'b0, i_cfg.mark_max}));
        o_item.is_one   = w_dur > $signed({1'b0, i_cfg.one_thr});
    end

endmodule

/* src/opfd_queue.sv */
// Short FIFO of classified durations between front and back.
// Depends on opfd_pkg.
module opfd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  opfd_pkg::t_item  i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output opfd_pkg::t_item  o_pop_data,
    output logic             o_empty
);

    opfd_pkg::t_item                r_mem [opfd_pkg::QUEUE_DEPTH];
    logic [opfd_pkg::QUEUE_AW-1:0]  r_wp;
    logic [opfd_pkg::QUEUE_AW-1:0]  r_rp;
    logic [opfd_pkg::QUEUE_AW:0]    r_cnt;

    assign o_full     = r_cnt == (opfd_pkg::QUEUE_AW+1)'(opfd_pkg::QUEUE_DEPTH);
    assign o_empty    = r_cnt == '0;
    assign o_pop_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* src/opfd_back.sv */
// Back end: preamble search, bit decoding, frame snapshot, status and output register.
// Depends on opfd_pkg.
module opfd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  opfd_pkg::t_cfg   i_cfg,
    input  logic             i_item_vld,
    input  opfd_pkg::t_item  i_item,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [2:0]       o_status,
    output logic [31:0]      o_data_word,
    output logic [7:0]       o_checksum_byte,
    output logic [5:0]       o_bit_count
);

    typedef enum logic [2:0] {
        PH_SEARCH = 3'b001,
        PH_DATA   = 3'b010,
        PH_DONE   = 3'b100
    } t_phase;

    localparam int IW = opfd_pkg::ICNT_W;
    localparam int DW = opfd_pkg::DCNT_W;
    localparam int BW = opfd_pkg::BITS_W;
    localparam int FB = opfd_pkg::FRAME_BITS;

    // sequence state
    t_phase              r_phase,  n_phase;
    opfd_pkg::t_pre      r_win [opfd_pkg::PRE_LEN];
    opfd_pkg::t_pre      n_win [opfd_pkg::PRE_LEN];
    logic [IW-1:0]       r_icnt,   n_icnt;
    logic [DW-1:0]       r_dcnt,   n_dcnt;
    logic [14:0]         r_pend,   n_pend;
    logic [FB-1:0]       r_bits,   n_bits;
    logic [BW-1:0]       r_taken,  n_taken;
    logic                r_err,    n_err;

    // finished-frame snapshot
    logic                r_fin_vld;
    logic                r_fin_eval;
    logic [2:0]          r_fin_status;
    logic [FB-1:0]       r_fin_bits;
    logic [BW-1:0]       r_fin_taken;

    // output register
    logic                r_out_vld;
    logic [2:0]          r_out_status;
    logic [31:0]         r_out_data;
    logic [7:0]          r_out_chk;
    logic [BW-1:0]       r_out_nbits;

    logic                w_fin_move;
    logic                w_fin_free;
    logic                w_seen;
    logic [16:0]         w_sum;
    logic                w_pair_ok;
    logic [2:0]          w_pre_status;
    logic                w_pre_eval;
    logic [31:0]         w_fin_data;
    logic [2:0]          w_eval_status;

    assign w_fin_move = r_fin_vld && (!r_out_vld || i_out_ready);
    assign w_fin_free = !r_fin_vld || w_fin_move;
    assign o_pop      = i_item_vld && (!i_item.last || w_fin_free);

    // preamble across the window after this item shifts in
    assign w_seen = r_win[1].pre_a && r_win[2].pre_b && r_win[3].pre_c && r_win[4].pre_b
                 && r_win[5].pre_c && r_win[6].pre_b && r_win[7].pre_c && i_item.pre_b;

    assign w_sum     = {i_item.duration[15], i_item.duration} + {2'b00, r_pend};
    assign w_pair_ok = ($signed(w_sum) >= $signed({1'b0, i_cfg.pair_min}))
                    && ($signed(w_sum) <= $signed({1'b0, i_cfg.pair_max}));

    always_comb begin
        n_phase = r_phase;
        n_win   = r_win;
        n_dcnt  = r_dcnt;
        n_pend  = r_pend;
        n_bits  = r_bits;
        n_taken = r_taken;
        n_err   = r_err;
        n_icnt  = (r_icnt == IW'(opfd_pkg::MIN_SEQUENCE)) ? r_icnt : r_icnt + 1'b1;

        unique case (r_phase)
            PH_SEARCH: begin
                for (int i = 0; i < opfd_pkg::PRE_LEN - 1; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_win[opfd_pkg::PRE_LEN-1] = '{pre_a: i_item.pre_a, pre_b: i_item.pre_b,
                                                pre_c: i_item.pre_c};
                if (w_seen) begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (!r_err) begin
                    if (!r_dcnt[0]) begin
                        if (!i_item.mark_ok) begin
                            n_err = 1'b1;
                        end else begin
                            n_bits  = {r_bits[FB-2:0], i_item.is_one};
                            n_taken = r_taken + 1'b1;
                            n_pend  = i_item.duration[14:0];
                        end
                    end else if (!i_item.mark_ok || !w_pair_ok) begin
                        n_err = 1'b1;
                    end
                end
                n_dcnt = r_dcnt + 1'b1;
                if (n_dcnt >= DW'(opfd_pkg::DATA_ITEMS)) begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE: begin
            end
            default: begin
                n_phase = PH_SEARCH;
            end
        endcase
    end

    // early status classes, known before the checksum is looked at
    always_comb begin
        w_pre_eval   = 1'b0;
        w_pre_status = opfd_pkg::ST_OK;
        if (n_icnt < IW'(opfd_pkg::MIN_SEQUENCE)) begin
            w_pre_status = opfd_pkg::ST_SHORT;
        end else if (n_phase == PH_SEARCH || n_dcnt < DW'(opfd_pkg::DATA_NEEDED)) begin
            w_pre_status = opfd_pkg::ST_NO_PRE;
        end else if (n_err) begin
            w_pre_status = opfd_pkg::ST_BAD;
        end else begin
            w_pre_eval = 1'b1;
        end
    end

    assign w_fin_data = r_fin_bits[FB-1:8];

    always_comb begin
        if ((w_fin_data & opfd_pkg::ZERO_MASK) == '0) begin
            w_eval_status = opfd_pkg::ST_ZERO;
        end else if (opfd_pkg::check_of(i_cfg.seed, w_fin_data) != r_fin_bits[7:0]) begin
            w_eval_status = opfd_pkg::ST_CHK;
        end else begin
            w_eval_status = opfd_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
            for (int i = 0; i < opfd_pkg::PRE_LEN; i++) begin
                r_win[i] <= '0;
            end
            r_icnt  <= '0;
            r_dcnt  <= '0;
            r_pend  <= '0;
            r_bits  <= '0;
            r_taken <= '0;
            r_err   <= 1'b0;
        end else if (o_pop) begin
            if (i_item.last) begin
                r_phase <= PH_SEARCH;
                for (int i = 0; i < opfd_pkg::PRE_LEN; i++) begin
                    r_win[i] <= '0;
                end
                r_icnt  <= '0;
                r_dcnt  <= '0;
                r_pend  <= '0;
                r_bits  <= '0;
                r_taken <= '0;
                r_err   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_win   <= n_win;
                r_icnt  <= n_icnt;
                r_dcnt  <= n_dcnt;
                r_pend  <= n_pend;
                r_bits  <= n_bits;
                r_taken <= n_taken;
                r_err   <= n_err;
            end
        end
    end

    // snapshot slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else if (o_pop && i_item.last) begin
            r_fin_vld <= 1'b1;
        end else if (w_fin_move) begin
            r_fin_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_fin_eval   <= w_pre_eval;
            r_fin_status <= w_pre_status;
            r_fin_bits   <= n_bits;
            r_fin_taken  <= n_taken;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fin_move) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_move) begin
            if (r_fin_eval) begin
                r_out_status <= w_eval_status;
                r_out_data   <= w_fin_data;
                r_out_chk    <= r_fin_bits[7:0];
                r_out_nbits  <= r_fin_taken;
            end else begin
                r_out_status <= r_fin_status;
                r_out_data   <= '0;
                r_out_chk    <= '0;
                r_out_nbits  <= '0;
            end
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_status        = r_out_status;
    assign o_data_word     = r_out_data;
    assign o_checksum_byte = r_out_chk;
    assign o_bit_count     = 6'(r_out_nbits);

endmodule

/* src/ook_pulse_frame_decoder_unit.sv */
// Top level of the OOK pulse frame decoder: configuration registers and the front/queue/back chain.
// Depends on opfd_pkg, opfd_front, opfd_queue and opfd_back.

// The decoder takes one pulse or gap duration per transaction, up to one per clock, and
// gives one status transaction for every sequence, after the duration marked last_item.
// A four-entry queue separates classification from decoding, so input keeps flowing while
// a result waits on the output; input stalls only when two statuses already wait (snapshot
// and output registers) and a third sequence end sits at the head of a full queue.
// Sustained rate is one duration per cycle while the output keeps up, set by the back end,
// which retires one queued duration each cycle unless a sequence end waits for a free
// snapshot slot. With no stalls a status passes from the queue through the snapshot
// register into the output register, where the checksum is checked.
// The decoder looks for the first preamble of eight durations in fixed windows, then
// takes 40 mark/gap bits, first bit most significant; the last gap may be missing.
// Status codes: 0 ok, 1 too short, 2 no preamble or incomplete frame, 3 bad pulse,
// 4 all-zero data, 5 checksum mismatch; for codes 1 to 3 the data fields read zero.
// Configuration writes take effect at once and belong only to idle periods.
module ook_pulse_frame_decoder_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [opfd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [opfd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // duration input
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [15:0]                         i_duration,
    input  logic                                i_last_item,
    // status output
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [2:0]                          o_status,
    output logic [31:0]                         o_data_word,
    output logic [7:0]                          o_checksum_byte,
    output logic [5:0]                          o_bit_count
);

    opfd_pkg::t_cfg   r_cfg;
    opfd_pkg::t_item  w_front_item;
    opfd_pkg::t_item  w_q_item;
    logic             w_q_full;
    logic             w_q_empty;
    logic             w_q_pop;
    logic             w_push;

    // config registers, reset to their documented defaults
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mark_min <= 15'd150;
            r_cfg.mark_max <= 15'd700;
            r_cfg.pair_min <= 16'd750;
            r_cfg.pair_max <= 16'd950;
            r_cfg.one_thr  <= 15'd400;
            r_cfg.seed     <= 8'h53;
        end else if (i_cfg_we) begin
            unique case (opfd_pkg::t_reg_idx'(i_cfg_idx))
                opfd_pkg::REG_MARK_MIN: r_cfg.mark_min <= i_cfg_data[14:0];
                opfd_pkg::REG_MARK_MAX: r_cfg.mark_max <= i_cfg_data[14:0];
                opfd_pkg::REG_PAIR_MIN: r_cfg.pair_min <= i_cfg_data;
                opfd_pkg::REG_PAIR_MAX: r_cfg.pair_max <= i_cfg_data;
                opfd_pkg::REG_ONE_THR:  r_cfg.one_thr  <= i_cfg_data[14:0];
                opfd_pkg::REG_SEED:     r_cfg.seed     <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // input is taken whenever the queue has room
    assign o_in_ready = !w_q_full;
    assign w_push     = i_in_valid && !w_q_full;

    opfd_front u_front (
        .i_duration  (i_duration),
        .i_last_item (i_last_item),
        .i_cfg       (r_cfg),
        .o_item      (w_front_item)
    );

    opfd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_front_item),
        .o_full      (w_q_full),
        .i_pop       (w_q_pop),
        .o_pop_data  (w_q_item),
        .o_empty     (w_q_empty)
    );

    opfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_item_vld      (!w_q_empty),
        .i_item          (w_q_item),
        .o_pop           (w_q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_data_word     (o_data_word),
        .o_checksum_byte (o_checksum_byte),
        .o_bit_count     (o_bit_count)
    );

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for ook_pulse_frame_decoder_unit: drives duration transactions,
// predicts each sequence status in its own decoder copy and checks every status transaction.
// Depends on opfd_pkg and the decoder RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // run control
    localparam int CYCLE_LIMIT   = 300000;  // generous bound for the slowest correct run
    localparam int SETTLE_CYCLES = 16;      // four-entry queue plus two output stages, and margin
    localparam int HOLD_CYCLES   = 300;     // long output hold-off for the back-pressure test
    localparam int ITEM_BUDGET   = 1850;    // whole run; random traffic gets what is left

    // decoder constants, kept separate from the RTL on purpose
    localparam logic [31:0] DATA_MASK = 32'h00ff_0fff;
    localparam logic [7:0]  CRC_POLY  = 8'h31;
    localparam int WIN_A_LO = 300, WIN_A_HI = 450;
    localparam int WIN_B_LO = 700, WIN_B_HI = 850;
    localparam int WIN_C_LO = 850, WIN_C_HI = 1000;
    localparam int PAIRS    = opfd_pkg::FRAME_BITS;
    localparam int DATA_LEN = 2 * opfd_pkg::FRAME_BITS;

    typedef enum logic [1:0] {HUNT, DECODE, FRAME_DONE} t_hunt_state;
    typedef enum int {FW_GOOD, FW_BADCHK, FW_ZERO} t_word_kind;

    typedef struct {
        int mark_min;
        int mark_max;
        int pair_min;
        int pair_max;
        int one_thr;
        int seed;
    } t_settings;

    typedef struct {
        opfd_pkg::t_status status;
        logic [31:0]       data;
        logic [7:0]        chk;
        logic [5:0]        nbits;
    } t_result;

    // DUT ports
    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [opfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [opfd_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [15:0]                     i_duration;
    logic                            i_last_item;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [2:0]                      o_status;
    logic [31:0]                     o_data_word;
    logic [7:0]                      o_checksum_byte;
    logic [5:0]                      o_bit_count;

    // decoder copy: settings and per-sequence state
    t_settings   cfg;
    int          win [8];
    int          seq_items;
    t_hunt_state hunt;
    int          held_mark;
    logic [39:0] bits_acc;
    int          bits_n;
    bit          pulse_bad;
    int          data_n;

    t_result status_due [$];   // statuses predicted, not yet seen on the output
    int      seq_q [$];        // durations of the sequence being built

    int items_sent    = 0;
    int mismatches    = 0;
    int cycle_n       = 0;
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int hold_left     = 0;
    bit edge_pick     = 1'b0;  // stimulus picks window edges instead of random values

    ook_pulse_frame_decoder_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_duration      (i_duration),
        .i_last_item     (i_last_item),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_data_word     (o_data_word),
        .o_checksum_byte (o_checksum_byte),
        .o_bit_count     (o_bit_count)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_n++;
        if (cycle_n >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Decoder copy
    // ------------------------------------------------------------------

    function automatic t_settings default_settings();
        t_settings s;
        s.mark_min = 150;
        s.mark_max = 700;
        s.pair_min = 750;
        s.pair_max = 950;
        s.one_thr  = 400;
        s.seed     = 8'h53;
        return s;
    endfunction

    function automatic logic [7:0] crc8_fold(input logic [7:0] seed, input logic [31:0] w);
        logic [7:0] c;
        c = seed ^ w[31:24] ^ w[23:16] ^ w[15:8] ^ w[7:0];
        repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        return c;
    endfunction

    function automatic void clear_frame();
        foreach (win[i]) win[i] = 0;
        seq_items = 0;
        hunt      = HUNT;
        held_mark = 0;
        bits_acc  = '0;
        bits_n    = 0;
        pulse_bad = 1'b0;
        data_n    = 0;
    endfunction

    // open windows: A first, then B at odd and C at even positions
    function automatic bit preamble_found();
        bit ok;
        ok = (win[0] > WIN_A_LO) && (win[0] < WIN_A_HI);
        for (int i = 1; i < 8; i++) begin
            if (i % 2 == 1) ok &= (win[i] > WIN_B_LO) && (win[i] < WIN_B_HI);
            else            ok &= (win[i] > WIN_C_LO) && (win[i] < WIN_C_HI);
        end
        return ok;
    endfunction

    // one accepted duration; a status is predicted on the last of a sequence
    function automatic void absorb_duration(input logic signed [15:0] d, input bit last);
        int      v;
        int      pair;
        bit      in_win;
        t_result r;
        v = d;
        if (seq_items < 65535) seq_items++;
        in_win = (v >= cfg.mark_min) && (v <= cfg.mark_max);
        if (hunt == HUNT) begin
            for (int i = 0; i < 7; i++) win[i] = win[i + 1];
            win[7] = v;
            if (seq_items >= 8 && preamble_found()) hunt = DECODE;
        end else if (hunt == DECODE) begin
            if (!pulse_bad) begin
                if (data_n % 2 == 0) begin
                    // mark
                    if (!in_win) begin
                        pulse_bad = 1'b1;
                    end else begin
                        bits_acc  = {bits_acc[38:0], v > cfg.one_thr};
                        bits_n++;
                        held_mark = v;
                    end
                end else begin
                    // gap, checked alone and as a pair with its mark
                    pair = v + held_mark;
                    if (!in_win || pair < cfg.pair_min || pair > cfg.pair_max) pulse_bad = 1'b1;
                end
            end
            data_n++;
            if (data_n >= DATA_LEN) hunt = FRAME_DONE;
        end
        if (!last) return;

        r.status = opfd_pkg::ST_OK;
        r.data   = '0;
        r.chk    = '0;
        r.nbits  = '0;
        if (seq_items < opfd_pkg::MIN_SEQUENCE) begin
            r.status = opfd_pkg::ST_SHORT;
        end else if (hunt == HUNT || data_n < DATA_LEN - 1) begin
            r.status = opfd_pkg::ST_NO_PRE;
        end else if (pulse_bad) begin
            r.status = opfd_pkg::ST_BAD;
        end else begin
            r.data  = bits_acc[39:8];
            r.chk   = bits_acc[7:0];
            r.nbits = bits_n[5:0];
            if ((r.data & DATA_MASK) == 0) begin
                r.status = opfd_pkg::ST_ZERO;
            end else if (crc8_fold(cfg.seed[7:0], r.data) != r.chk) begin
                r.status = opfd_pkg::ST_CHK;
            end
        end
        status_due.push_back(r);
        clear_frame();
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    function automatic int pick_in(input int lo, input int hi);
        if (lo > hi) return lo;  // no legal value: caller gets an out-of-window one
        if (edge_pick) return $urandom_range(1, 0) ? lo : hi;
        return lo + int'($urandom_range(hi - lo, 0));
    endfunction

    function automatic int pick_mark(input bit one);
        if (one) return pick_in((cfg.one_thr + 1 > cfg.mark_min) ? cfg.one_thr + 1 : cfg.mark_min,
                                cfg.mark_max);
        return pick_in(cfg.mark_min, (cfg.one_thr < cfg.mark_max) ? cfg.one_thr : cfg.mark_max);
    endfunction

    function automatic int pick_gap(input int m);
        int lo, hi;
        lo = (cfg.pair_min - m > cfg.mark_min) ? cfg.pair_min - m : cfg.mark_min;
        hi = (cfg.pair_max - m < cfg.mark_max) ? cfg.pair_max - m : cfg.mark_max;
        return pick_in(lo, hi);
    endfunction

    function automatic logic [39:0] frame_word(input t_word_kind kind);
        logic [31:0] w;
        logic [7:0]  c;
        w = $urandom();
        if (kind == FW_ZERO)             w &= ~DATA_MASK;
        else if ((w & DATA_MASK) == 0)   w[0] = 1'b1;
        c = crc8_fold(cfg.seed[7:0], w);
        if (kind == FW_BADCHK) c ^= 8'($urandom_range(255, 1));
        return {w, c};
    endfunction

    function automatic void add_preamble();
        seq_q.push_back($urandom_range(WIN_A_HI - 1, WIN_A_LO + 1));
        for (int i = 1; i < 8; i++) begin
            if (i % 2 == 1) seq_q.push_back($urandom_range(WIN_B_HI - 1, WIN_B_LO + 1));
            else            seq_q.push_back($urandom_range(WIN_C_HI - 1, WIN_C_LO + 1));
        end
    endfunction

    function automatic void add_frame(input logic [39:0] w, input bit drop_gap);
        int m;
        for (int i = PAIRS - 1; i >= 0; i--) begin
            m = pick_mark(w[i]);
            seq_q.push_back(m);
            if (i != 0 || !drop_gap) seq_q.push_back(pick_gap(m));
        end
    endfunction

    function automatic void add_noise(input int n);
        repeat (n) seq_q.push_back(int'($urandom_range(65535, 0)) - 32768);
    endfunction

    // mostly well-formed frames with random content; the rest noise and broken frames
    function automatic void build_random_sequence();
        int  pick;
        int  first;
        int  kind_pick;
        bit  cut;
        pick = $urandom_range(99, 0);
        if (pick < 12) begin
            add_noise($urandom_range(opfd_pkg::MIN_SEQUENCE - 1, 1));
            return;
        end
        if (pick < 17) begin
            add_noise($urandom_range(120, opfd_pkg::MIN_SEQUENCE));
            return;
        end
        if ($urandom_range(2, 0) == 0) add_noise($urandom_range(6, 1));
        add_preamble();
        first     = seq_q.size();
        kind_pick = $urandom_range(99, 0);
        add_frame(frame_word(kind_pick < 70 ? FW_GOOD : (kind_pick < 85 ? FW_BADCHK : FW_ZERO)),
                  $urandom_range(9, 0) < 3);
        cut = 1'b0;
        if (pick >= 80 && pick < 92) begin
            // one data duration replaced by a value above the mark window or a random one
            seq_q[first + $urandom_range(seq_q.size() - first - 1, 0)] =
                $urandom_range(1, 0) ? cfg.mark_max + 1 : int'($urandom_range(65535, 0)) - 32768;
        end else if (pick >= 92) begin
            repeat ($urandom_range(20, 2)) void'(seq_q.pop_back());
            cut = 1'b1;
        end
        if (!cut && $urandom_range(3, 0) == 0) add_noise($urandom_range(5, 1));
    endfunction

    // ------------------------------------------------------------------
    // Drivers and checker
    // ------------------------------------------------------------------

    // called at a falling edge; returns at the falling edge after the transaction,
    // with valid still high so back-to-back transactions need no extra assignment
    task automatic send_duration(input int d, input bit last);
        while ($urandom_range(99, 0) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_duration  <= d[15:0];
        i_last_item <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        absorb_duration(d[15:0], last);
        @(negedge i_clk);
    endtask

    task automatic send_sequence();
        int n;
        n = seq_q.size();
        for (int k = 0; k < n; k++) send_duration(seq_q[k], k == n - 1);
        seq_q.delete();
    endtask

    // drop valid, wait for every predicted status, then let the pipeline empty
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (status_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic put_reg(input opfd_pkg::t_reg_idx r, input int v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= r;
        i_cfg_data <= v[15:0];
        @(negedge i_clk);
    endtask

    // only while idle
    task automatic load_settings(input t_settings s);
        put_reg(opfd_pkg::REG_MARK_MIN, s.mark_min);
        put_reg(opfd_pkg::REG_MARK_MAX, s.mark_max);
        put_reg(opfd_pkg::REG_PAIR_MIN, s.pair_min);
        put_reg(opfd_pkg::REG_PAIR_MAX, s.pair_max);
        put_reg(opfd_pkg::REG_ONE_THR,  s.one_thr);
        put_reg(opfd_pkg::REG_SEED,     s.seed);
        i_cfg_we <= 1'b0;
        cfg = s;
    endtask

    // receiver: long hold-off when requested, random stalls otherwise
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else begin
            i_out_ready <= ($urandom_range(99, 0) >= rcv_stall_pct);
        end
    end

    // every status transaction against the oldest prediction
    always @(posedge i_clk) begin : check_status
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (status_due.size() == 0) begin
                $display("%0t ns: status transaction with none predicted, got status %0d",
                         $time, o_status);
                mismatches++;
            end else begin
                want = status_due.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t ns: status expected %0d, got %0d", $time, want.status, o_status);
                    mismatches++;
                end
                if (o_data_word !== want.data) begin
                    $display("%0t ns: data_word expected %h, got %h", $time, want.data,
                             o_data_word);
                    mismatches++;
                end
                if (o_checksum_byte !== want.chk) begin
                    $display("%0t ns: checksum_byte expected %h, got %h", $time, want.chk,
                             o_checksum_byte);
                    mismatches++;
                end
                if (o_bit_count !== want.nbits) begin
                    $display("%0t ns: bit_count expected %0d, got %0d", $time, want.nbits,
                             o_bit_count);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // named cases at the reset settings, no idling
    task automatic test_directed_cases();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        // clean frame
        add_preamble(); add_frame(frame_word(FW_GOOD), 1'b0); send_sequence();
        // final gap missing: exactly the shortest legal sequence
        add_preamble(); add_frame(frame_word(FW_GOOD), 1'b1); send_sequence();
        // checksum mismatch
        add_preamble(); add_frame(frame_word(FW_BADCHK), 1'b0); send_sequence();
        // masked data all zero, bits outside the mask random
        add_preamble(); add_frame(frame_word(FW_ZERO), 1'b0); send_sequence();
        // marks and gaps on the inclusive window edges and the one threshold
        edge_pick = 1'b1;
        add_preamble(); add_frame(frame_word(FW_GOOD), 1'b0); send_sequence();
        add_preamble(); add_frame(frame_word(FW_GOOD), 1'b1); send_sequence();
        edge_pick = 1'b0;
        // sequence of one transaction
        seq_q.push_back(400); send_sequence();
        // one short of the minimum length
        add_preamble(); add_frame(frame_word(FW_GOOD), 1'b1); void'(seq_q.pop_back());
        send_sequence();
        // no preamble at all
        repeat (100) seq_q.push_back(500);
        send_sequence();
        // preamble window bounds are exclusive
        add_preamble(); seq_q[0] = WIN_A_LO; add_frame(frame_word(FW_GOOD), 1'b0);
        send_sequence();
        // extreme durations before and after a good frame
        seq_q.push_back(-32768); seq_q.push_back(32767); seq_q.push_back(0); seq_q.push_back(-1);
        add_preamble(); add_frame(frame_word(FW_GOOD), 1'b0);
        seq_q.push_back(-32768); seq_q.push_back(32767);
        send_sequence();
        // partial preamble just ahead of the real one
        add_preamble(); void'(seq_q.pop_back()); add_preamble();
        add_frame(frame_word(FW_GOOD), 1'b0); send_sequence();
        // frame cut short after the preamble, long enough overall
        repeat (10) seq_q.push_back(100);
        add_preamble(); add_frame(frame_word(FW_GOOD), 1'b0);
        repeat (3) void'(seq_q.pop_back());
        send_sequence();
        // cut-short frame with a bad pulse still reads as incomplete
        repeat (10) seq_q.push_back(100);
        add_preamble(); add_frame(frame_word(FW_GOOD), 1'b0);
        repeat (3) void'(seq_q.pop_back());
        seq_q[30] = -5;
        send_sequence();
        // mark below its window
        add_preamble(); add_frame(frame_word(FW_GOOD), 1'b0);
        seq_q[opfd_pkg::PRE_LEN + 10] = cfg.mark_min - 1; send_sequence();
        // gap above its window
        add_preamble(); add_frame(frame_word(FW_GOOD), 1'b0);
        seq_q[opfd_pkg::PRE_LEN + 11] = cfg.mark_max + 1; send_sequence();
        // mark and gap each legal, their sum too long
        add_preamble(); add_frame(frame_word(FW_GOOD), 1'b0);
        seq_q[opfd_pkg::PRE_LEN + 20] = 600; seq_q[opfd_pkg::PRE_LEN + 21] = 600;
        send_sequence();
        // most negative duration as a mark
        add_preamble(); add_frame(frame_word(FW_GOOD), 1'b0);
        seq_q[opfd_pkg::PRE_LEN + 4] = -32768; send_sequence();
        // bad final mark, then bad final gap
        add_preamble(); add_frame(frame_word(FW_GOOD), 1'b0);
        seq_q[opfd_pkg::PRE_LEN + DATA_LEN - 2] = 0; send_sequence();
        add_preamble(); add_frame(frame_word(FW_GOOD), 1'b0);
        seq_q[opfd_pkg::PRE_LEN + DATA_LEN - 1] = 10000; send_sequence();
        wait_idle();
    endtask

    // every register at its extremes
    task automatic test_register_extremes();
        t_settings s;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        // all zero: only zero-length pulses fit
        s.mark_min = 0; s.mark_max = 0; s.pair_min = 0; s.pair_max = 0;
        s.one_thr = 0; s.seed = 0;
        load_settings(s);
        add_preamble(); add_frame(40'd0, 1'b0); send_sequence();
        add_preamble(); add_frame(frame_word(FW_GOOD), 1'b0); send_sequence();
        wait_idle();
        // all at maximum
        s.mark_min = 32767; s.mark_max = 32767; s.pair_min = 65535; s.pair_max = 65535;
        s.one_thr = 32767; s.seed = 255;
        load_settings(s);
        add_preamble(); add_frame(frame_word(FW_GOOD), 1'b0); send_sequence();
        wait_idle();
        // widest windows, threshold at each end
        s.mark_min = 0; s.mark_max = 32767; s.pair_min = 0; s.pair_max = 65535;
        s.one_thr = 0; s.seed = 8'hff;
        load_settings(s);
        add_preamble(); add_frame(frame_word(FW_GOOD), 1'b0); send_sequence();
        add_preamble(); add_frame(frame_word(FW_BADCHK), 1'b1); send_sequence();
        wait_idle();
        s.one_thr = 32767; s.seed = 0;
        load_settings(s);
        add_preamble(); add_frame(40'd0, 1'b0); send_sequence();
        wait_idle();
    endtask

    function automatic t_settings random_settings();
        t_settings s;
        s.mark_min = $urandom_range(300, 20);
        s.mark_max = s.mark_min + int'($urandom_range(800, 200));
        s.one_thr  = $urandom_range(s.mark_max - 1, s.mark_min);
        // pair_min <= min+max <= pair_max keeps every mark decodable
        s.pair_min = $urandom_range(s.mark_min + s.mark_max, 0);
        s.pair_max = s.mark_min + s.mark_max + int'($urandom_range(500, 0));
        s.seed     = $urandom_range(255, 0);
        return s;
    endfunction

    // random sequences in four idling phases, each with its own settings;
    // the phases share what is left of the item budget, one sequence at least
    task automatic test_random_traffic();
        t_settings s;
        int start_items;
        int quota;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    snd_idle_pct = 0;  rcv_stall_pct = 0;
                    s = default_settings();
                end
                1: begin
                    snd_idle_pct = 71; rcv_stall_pct = 0;
                    s = random_settings();
                end
                2: begin
                    snd_idle_pct = 0;  rcv_stall_pct = 71;
                    s.mark_min = 0; s.mark_max = 32767; s.pair_min = 0; s.pair_max = 65535;
                    s.one_thr = $urandom_range(32766, 0); s.seed = $urandom_range(255, 0);
                end
                default: begin
                    snd_idle_pct = 37; rcv_stall_pct = 37;
                    s = random_settings();
                end
            endcase
            load_settings(s);
            start_items = items_sent;
            quota       = (ITEM_BUDGET - items_sent) / (4 - p);
            do begin
                build_random_sequence();
                send_sequence();
            end while (items_sent - start_items < quota);
            wait_idle();
        end
    endtask

    // output held off while short sequences keep coming, so the input stalls
    task automatic test_output_backpressure();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        @(posedge i_clk);
        hold_left = HOLD_CYCLES;
        @(negedge i_clk);
        repeat (24) begin
            add_noise($urandom_range(3, 1));
            send_sequence();
        end
        add_preamble(); add_frame(frame_word(FW_GOOD), 1'b0); send_sequence();
        wait_idle();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_duration  = '0;
        i_last_item = 1'b0;
        i_out_ready = 1'b0;
        cfg = default_settings();
        clear_frame();

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_register_extremes();
        test_output_backpressure();
        test_random_traffic();

        if (mismatches == 0) $display("SUCCESS");
        else                 $display("FAILURE");
        $finish;
    end

endmodule
